/* rtl/core/pidm_pkg.sv */
package pidm_pkg;

  localparam int unsigned MaxLanes   = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ProdW      = 16;
  localparam int unsigned AccW       = 32;
  localparam int unsigned LaneIdxW   = 2;
  localparam int unsigned PackedW    = 25;
  localparam int unsigned MulW       = 33;
  localparam int unsigned InDataW    = 9 * ByteW;
  localparam int unsigned OutFieldsW = LaneIdxW + 2 * AccW;
  localparam int unsigned OutDataW   = ((OutFieldsW + ByteW - 1) / ByteW) * ByteW;

  typedef logic [ProdW-1:0]    prod_t;
  typedef logic [AccW-1:0]     acc_t;
  typedef logic [LaneIdxW-1:0] lane_idx_t;

  // Queue occupancy seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/core/pidm_front.sv */
module pidm_front #(
  parameter int unsigned LANES = 4
) (
  input  logic [pidm_pkg::InDataW-1:0]      s_data_i,
  input  logic                              s_last_i,
  output logic [LANES*2*pidm_pkg::ProdW:0]  q_wdata_o
);

  localparam int unsigned PW = pidm_pkg::ProdW;
  localparam int unsigned BW = pidm_pkg::ByteW;

  logic signed [BW-1:0] act;

  assign act = s_data_i[BW-1:0];

  // Pack both weights into one operand and split the shared product.
  for (genvar n = 0; n < LANES; n++) begin : g_lane
    logic signed [BW-1:0]                 w_lo;
    logic signed [BW-1:0]                 w_hi;
    logic signed [pidm_pkg::PackedW-1:0]  packed_w;
    logic signed [pidm_pkg::MulW-1:0]     prod;
    pidm_pkg::prod_t                      p_lo;
    pidm_pkg::prod_t                      p_hi;

    assign w_lo     = s_data_i[(2*n+1)*BW +: BW];
    assign w_hi     = s_data_i[(2*n+2)*BW +: BW];
    assign packed_w = {w_hi[BW-1], w_hi, {PW{1'b0}}}
                    + {{(pidm_pkg::PackedW-BW){w_lo[BW-1]}}, w_lo};
    assign prod     = act * packed_w;
    assign p_lo     = prod[PW-1:0];
    // add back the borrow taken by a negative low product
    assign p_hi     = prod[2*PW-1:PW] + {{(PW-1){1'b0}}, prod[PW-1]};

    assign q_wdata_o[n*2*PW +: 2*PW] = {p_hi, p_lo};
  end

  assign q_wdata_o[LANES*2*PW] = s_last_i;

endmodule

/* rtl/core/pidm_fifo.sv */
module pidm_fifo #(
  parameter int unsigned Width = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [Width-1:0]     rdata_o,
  output pidm_pkg::q_status_t  status_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o        = mem_q[rd_ptr_q];
  assign status_o.full  = count_q[1];
  assign status_o.empty = (count_q == 2'd0);

endmodule

/* rtl/core/pidm_back.sv */
module pidm_back #(
  parameter int unsigned LANES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [LANES*2*pidm_pkg::ProdW:0]  q_rdata_i,
  input  pidm_pkg::q_status_t               q_status_i,
  output logic                              q_pop_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [pidm_pkg::OutDataW-1:0]     m_data_o,
  output logic                              m_last_o
);

  localparam int unsigned PW = pidm_pkg::ProdW;
  localparam int unsigned AW = pidm_pkg::AccW;
  localparam pidm_pkg::lane_idx_t LastLane = pidm_pkg::LaneIdxW'(LANES - 1);

  pidm_pkg::acc_t      acc_lo_q  [LANES];
  pidm_pkg::acc_t      acc_hi_q  [LANES];
  pidm_pkg::acc_t      snap_lo_q [LANES];
  pidm_pkg::acc_t      snap_hi_q [LANES];
  pidm_pkg::acc_t      sum_lo    [LANES];
  pidm_pkg::acc_t      sum_hi    [LANES];
  logic                snap_valid_q, snap_valid_d;
  pidm_pkg::lane_idx_t lane_q, lane_d;
  logic                head_last;
  logic                out_fire;
  logic                snap_done;
  logic                close_run;

  assign head_last = q_rdata_i[LANES*2*PW];
  assign out_fire  = snap_valid_q && m_ready_i;
  assign snap_done = out_fire && (lane_q == LastLane);
  // a last term may enter only when the snapshot bank is free or freeing
  assign q_pop_o   = !q_status_i.empty && (!head_last || !snap_valid_q || snap_done);
  assign close_run = q_pop_o && head_last;

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    pidm_pkg::prod_t p_lo;
    pidm_pkg::prod_t p_hi;

    assign p_lo      = q_rdata_i[n*2*PW +: PW];
    assign p_hi      = q_rdata_i[n*2*PW+PW +: PW];
    assign sum_lo[n] = acc_lo_q[n] + {{(AW-PW){p_lo[PW-1]}}, p_lo};
    assign sum_hi[n] = acc_hi_q[n] + {{(AW-PW){p_hi[PW-1]}}, p_hi};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_lo_q[n] <= '0;
        acc_hi_q[n] <= '0;
      end else if (q_pop_o) begin
        acc_lo_q[n] <= head_last ? '0 : sum_lo[n];
        acc_hi_q[n] <= head_last ? '0 : sum_hi[n];
      end
    end

    always_ff @(posedge clk_i) begin
      if (close_run) begin
        snap_lo_q[n] <= sum_lo[n];
        snap_hi_q[n] <= sum_hi[n];
      end
    end
  end

  always_comb begin
    snap_valid_d = snap_valid_q;
    lane_d       = lane_q;
    if (close_run) begin
      snap_valid_d = 1'b1;
      lane_d       = '0;
    end else if (snap_done) begin
      snap_valid_d = 1'b0;
    end else if (out_fire) begin
      lane_d = lane_q + pidm_pkg::lane_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      lane_q       <= '0;
    end else begin
      snap_valid_q <= snap_valid_d;
      lane_q       <= lane_d;
    end
  end

  assign m_valid_o = snap_valid_q;
  assign m_last_o  = (lane_q == LastLane);
  assign m_data_o  = {{(pidm_pkg::OutDataW-pidm_pkg::OutFieldsW){1'b0}},
                      snap_hi_q[lane_q], snap_lo_q[lane_q], lane_q};

endmodule

/* rtl/core/packed_int8_dual_mac_array_top.sv */
// Channel   Dir  Width  Contents (lowest bit up)
// s_axis    in   72+1   activation, weight_0 .. weight_7; tlast = last_term
// m_axis    out  72+1   lane_index, sum_low, sum_high, zero pad; tlast = last_result
//
// One input transaction per cycle while the queue is not full; a last term adds LANES results
// on m_axis, limited by the single output port walking the lanes in order.
// Products are formed combinationally and registered into a two-entry queue; accumulation and snapshot follow.
// Reset clears the accumulators, queue pointers and output state.
// s_axis stalls only when the queue is full; a last term waits in the queue
// while an earlier snapshot is still being drained.
module packed_int8_dual_mac_array_top #(
  parameter int unsigned LANES = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pidm_pkg::InDataW-1:0]   s_axis_tdata,  // activation, weight_0..weight_7
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pidm_pkg::OutDataW-1:0]  m_axis_tdata,  // lane_index, sum_low, sum_high
  output logic                           m_axis_tlast
);

  localparam int unsigned QW = LANES * 2 * pidm_pkg::ProdW + 1;

  logic [QW-1:0]       q_wdata;
  logic [QW-1:0]       q_rdata;
  logic                q_push;
  logic                q_pop;
  pidm_pkg::q_status_t q_status;

  assign s_axis_tready = !q_status.full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  pidm_front #(.LANES(LANES)) u_front (
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .q_wdata_o (q_wdata)
  );

  pidm_fifo #(.Width(QW)) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wdata_i  (q_wdata),
    .pop_i    (q_pop),
    .rdata_o  (q_rdata),
    .status_o (q_status)
  );

  pidm_back #(.LANES(LANES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_rdata_i  (q_rdata),
    .q_status_i (q_status),
    .q_pop_o    (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule
